/* hdl/rsmp_pkg.sv */
// Shared types and constants for the reservoir sampler.
// Used by rsmp_div and reservoir_sampler; depends on nothing.
package rsmp_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned FILL_W     = $clog2(SLOTS + 1);
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned SIZE_W     = 5;

  localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [FILL_W-1:0] SLOTS_F   = FILL_W'(SLOTS);
  localparam logic [SIZE_W-1:0] SLOTS_S   = SIZE_W'(SLOTS);

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] element_value;
    logic [31:0] random_draw;
    logic [3:0]  slot_index;
  } in_word_t;

  typedef struct packed {
    logic        stored;
    logic [3:0]  stored_slot;
    logic [31:0] read_value;
    logic [4:0]  filled;
    logic        count_saturated;
  } out_word_t;

endpackage

/* hdl/rsmp_div.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on rsmp_pkg for the operand width.
module rsmp_div import rsmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [CNT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] rem_o
);

  localparam int unsigned STEP_W = $clog2(CNT_W);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  shf_q, dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [CNT_W:0]    trial;

  // Shift in the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem_q, shf_q[CNT_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      trial = trial - {1'b0, dvs_q};
    end
    rem_d = trial[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == STEP_W'(CNT_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(CNT_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      shf_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      shf_q <= {shf_q[CNT_W-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/reservoir_sampler.sv */
// Reservoir sampler top level: sequencer, slot memory, run counters.
// Depends on rsmp_pkg and rsmp_div.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i / in_stall_o    in_word_t (operation, value, draw, slot)
//   out      output     out_valid_o / out_stall_i  out_word_t (stored, slot, value, fill, sat)
//   cfg      input      cfg_valid_i / cfg_ready_o  reservoir_size, 5 bits
//
// A fill-phase offer, a read, a clear or the unused code goes from accept through
// ST_FINISH into the result register; an offer past the fill point waits first in
// ST_DIVIDE for the bit-serial 32-bit remainder of the draw by the seen count. The
// input stalls until the result shows, and then only while the output stalls.
// Reset is asynchronous, active low: clear counters, flag and control, size 16.
// A stalled result holds the result register and stalls the input.
module reservoir_sampler import rsmp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SIZE_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e                state_q;
  logic [CNT_W-1:0]      seen_q;
  logic                  sat_q;
  logic [SIZE_W-1:0]     size_q;
  logic                  stored_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [VALUE_BITS-1:0] rdata_q;
  logic                  out_valid_q;
  out_word_t             out_q;

  logic [VALUE_BITS-1:0] mem [SLOTS];

  logic              in_acc, out_acc;
  logic [FILL_W-1:0] eff_size, fill;
  logic [CNT_W-1:0]  seen_next;
  logic              div_start, div_done;
  logic [CNT_W-1:0]  div_rem;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic              fill_phase, rem_hit;
  logic              offer_op;

  // Clamp the size register to 1..SLOTS.
  always_comb begin
    if (size_q == '0) begin
      eff_size = FILL_W'(1);
    end else if (size_q > SLOTS_S) begin
      eff_size = SLOTS_F;
    end else begin
      eff_size = FILL_W'(size_q);
    end
  end

  assign fill = (seen_q < CNT_W'(eff_size)) ? seen_q[FILL_W-1:0] : eff_size;
  assign seen_next = (seen_q == COUNT_MAX) ? seen_q : seen_q + CNT_W'(1);

  assign out_acc    = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Offer while the reservoir is still filling: slot is the old count.
  assign offer_op   = in_data_i.operation == OP_OFFER;
  assign fill_phase = seen_q < CNT_W'(eff_size);
  assign rem_hit    = div_rem < CNT_W'(eff_size);
  assign div_start  = in_acc && offer_op && !fill_phase;

  rsmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (in_data_i.random_draw),
    .divisor_i  (seen_next),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Single write port: filling writes at accept, sampling writes on remainder.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = seen_q[SLOT_W-1:0];
    wr_data = in_data_i.element_value;
    if (in_acc && offer_op && fill_phase) begin
      wr_en = 1'b1;
    end else if ((state_q == ST_DIVIDE) && div_done && rem_hit) begin
      wr_en   = 1'b1;
      wr_addr = div_rem[SLOT_W-1:0];
      wr_data = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_acc) begin
      rdata_q <= mem[in_data_i.slot_index];
      val_q   <= in_data_i.element_value;
    end
  end

  // Sequencer, run state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      sat_q       <= 1'b0;
      size_q      <= SLOTS_S;
      stored_q    <= 1'b0;
      slot_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
      if (state_q == ST_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            stored_q <= offer_op && fill_phase;
            slot_q   <= (offer_op && fill_phase) ? seen_q[SLOT_W-1:0] : '0;
            hit_q    <= (in_data_i.operation == OP_READ) &&
                        ({1'b0, in_data_i.slot_index} < fill);
            state_q  <= (offer_op && !fill_phase) ? ST_DIVIDE : ST_FINISH;
            case (in_data_i.operation)
              OP_OFFER: begin
                seen_q <= seen_next;
                if (seen_next == COUNT_MAX) begin
                  sat_q <= 1'b1;
                end
              end
              OP_CLEAR: begin
                seen_q <= '0;
                sat_q  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIVIDE: begin
          // Keep the element only if the remainder of its draw lands inside the reservoir.
          if (div_done) begin
            if (rem_hit) begin
              stored_q <= 1'b1;
              slot_q   <= div_rem[SLOT_W-1:0];
            end
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Load the result once per word; it holds while stalled.
          out_q.stored          <= stored_q;
          out_q.stored_slot     <= slot_q;
          out_q.read_value      <= hit_q ? rdata_q : '0;
          out_q.filled          <= fill;
          out_q.count_saturated <= sat_q;
          state_q               <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule
